// ===== rtl/core/pfsl_pkg.sv =====
// ----------------------------------------------------------------------------
// pfsl_pkg: shared definitions for the push-front search list
// Widths, operation codes and the control bundle broadcast along the cells.
// ----------------------------------------------------------------------------
package pfsl_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int VALUE_W      = 32;
   localparam int MODE_W       = 2;

   // Operation codes carried in the mode field
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FIND   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

   // Command broadcast to every cell in the chain
   typedef struct packed {
      logic                      ins;  // shift one place towards the tail
      logic                      del;  // close the gap at the first match
      logic signed [VALUE_W-1:0] key;  // search key / inserted value
   } cell_ctl_type;

endpackage

// ===== rtl/core/pfsl_req_if.sv =====
// ----------------------------------------------------------------------------
// pfsl_req_if: request channel of the push-front search list
// Valid/ready handshake carrying one list operation per transaction.
// ----------------------------------------------------------------------------
interface pfsl_req_if
   import pfsl_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [MODE_W-1:0]         mode;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);
endinterface

// ===== rtl/core/pfsl_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pfsl_rsp_if: response channel of the push-front search list
// Valid/ready handshake carrying the outcome of one operation.
// ----------------------------------------------------------------------------
interface pfsl_rsp_if
   import pfsl_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) ();
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic             valid;
   logic             ready;
   logic             hit;
   logic             rejected;
   logic [CNT_W-1:0] count;
   logic             empty_res;

   modport source (output valid, output hit, output rejected, output count,
                   output empty_res, input ready);
   modport sink   (input valid, input hit, input rejected, input count,
                   input empty_res, output ready);
endinterface

// ===== rtl/core/pfsl_cell.sv =====
// ----------------------------------------------------------------------------
// pfsl_cell: one list position
// Holds one entry, compares it with the key and takes its neighbour's entry
// on an insert (from the head side) or a delete (from the tail side).
// ----------------------------------------------------------------------------
module pfsl_cell
   import pfsl_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int INDEX    = 0
) (
   input  logic                              clock,
   input  cell_ctl_type                      ctl,
   input  logic [$clog2(CAPACITY+1)-1:0]     count,
   input  logic signed [VALUE_W-1:0]         head_value,
   input  logic signed [VALUE_W-1:0]         tail_value,
   input  logic                              seen_in,
   output logic                              seen_out,
   output logic signed [VALUE_W-1:0]         value
);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;
   logic                      occupied;
   logic                      match;

   // Compare against the key; only occupied positions take part
   assign occupied = count > CNT_W'(INDEX);
   assign match    = occupied && (value_ff == ctl.key);
   assign seen_out = seen_in | match;
   assign value    = value_ff;

   // Advance on insert, pull from the tail side at and after the first match
   always_comb begin
      value_in = value_ff;
      if (ctl.ins) begin
         value_in = head_value;
      end else if (ctl.del && seen_out) begin
         value_in = tail_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== rtl/core/push_front_search_list.sv =====
// ----------------------------------------------------------------------------
// push_front_search_list: ordered list with insert at head, find and delete
// The outcome of each accepted request is held in a response register.
// Throughput: one operation per cycle while responses are taken; all cells
// compare and shift in parallel; the first-match flag ripples along the chain.
// Reset: synchronous, clears the entry count and the response valid.
// ----------------------------------------------------------------------------
module push_front_search_list
   import pfsl_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic       clock,
   input  logic       reset,
   pfsl_req_if.sink   req,
   pfsl_rsp_if.source rsp
);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic                      rsp_valid_ff;
   logic                      hit_ff;
   logic                      hit_in;
   logic                      rejected_ff;
   logic                      rejected_in;
   logic                      accept;
   logic                      full;
   logic                      op_insert;
   logic                      op_find;
   logic                      op_delete;
   cell_ctl_type              ctl;
   logic [CAPACITY:0]         seen;
   logic signed [VALUE_W-1:0] cell_value [CAPACITY];

   // Accept a new transaction whenever the response slot is free or leaving
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign full      = count_ff == CNT_W'(CAPACITY);

   // Decode the operation
   always_comb begin
      op_insert = 1'b0;
      op_find   = 1'b0;
      op_delete = 1'b0;
      unique case (req.mode)
         MODE_INSERT: op_insert = 1'b1;
         MODE_FIND:   op_find   = 1'b1;
         MODE_DELETE: op_delete = 1'b1;
         default:     ;
      endcase
   end

   assign ctl.ins = accept && op_insert && !full;
   assign ctl.del = accept && op_delete;
   assign ctl.key = req.value;

   // Chain of cells, head at position 0
   assign seen[0] = 1'b0;
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] head_value;
      logic signed [VALUE_W-1:0] tail_value;

      if (i == 0) begin : g_head
         assign head_value = req.value;
      end else begin : g_mid
         assign head_value = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign tail_value = cell_value[i];
      end else begin : g_body
         assign tail_value = cell_value[i+1];
      end

      pfsl_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .count      (count_ff),
         .head_value (head_value),
         .tail_value (tail_value),
         .seen_in    (seen[i]),
         .seen_out   (seen[i+1]),
         .value      (cell_value[i])
      );
   end

   // Work out the result and the new entry count
   always_comb begin
      hit_in      = (op_find || op_delete) && seen[CAPACITY];
      rejected_in = op_insert && full;
      count_in    = count_ff;
      if (ctl.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.del && seen[CAPACITY]) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Hold the count and the response control
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (req.ready) begin
            rsp_valid_ff <= req.valid;
         end
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         hit_ff      <= hit_in;
         rejected_ff <= rejected_in;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.hit       = hit_ff;
   assign rsp.rejected  = rejected_ff;
   assign rsp.count     = count_ff;
   assign rsp.empty_res = count_ff == '0;

endmodule

// ===== tb/push_front_search_list_tb.sv =====
// ----------------------------------------------------------------------------
// push_front_search_list_tb: self-checking bench for the push-front search list
// Runs a short directed sequence over the list extremes, then fill-and-drain
// random traffic with random valid and ready gaps and one long response
// stall. A scoreboard keeps its own copy of the list and compares every
// response field against it.
// ----------------------------------------------------------------------------
module push_front_search_list_tb;
   import pfsl_pkg::*;

   localparam int CAPACITY    = CAPACITY_DEF;
   localparam int HOLD_CYCLES = 48;
   localparam int RAND_ITEMS  = 1420;
   localparam int QUIET_FROM  = 1200;
   localparam int HOLD_AT     = 300;
   localparam int PHASE_LEN   = 40;

   // Mode code with no operation behind it
   localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

   // -------------------------------------------------------------------------
   // Scoreboard: shadow list plus queue of outcomes still owed by the block
   // -------------------------------------------------------------------------
   class list_scoreboard;
      localparam int DEPTH = CAPACITY_DEF;
      localparam int CNT_W = $clog2(DEPTH + 1);

      typedef struct packed {
         logic             hit;
         logic             rejected;
         logic [CNT_W-1:0] count;
         logic             empty_flag;
      } outcome_type;

      logic signed [VALUE_W-1:0] held [DEPTH];
      int                        held_count;
      outcome_type               owed_q [$];
      int                        errors;

      function new();
         held_count = 0;
         errors     = 0;
      endfunction

      task report(input string msg);
         $display("ERROR at %0t: %s", $time, msg);
         errors++;
      endtask

      // First match counted from the head, or held_count when absent
      function int locate(input logic signed [VALUE_W-1:0] key);
         int i;
         for (i = 0; i < held_count; i++) begin
            if (held[i] == key) return i;
         end
         return held_count;
      endfunction

      // Apply one accepted transaction to the shadow list and queue its outcome
      function void note_request(input logic [MODE_W-1:0] mode,
                                 input logic signed [VALUE_W-1:0] value);
         outcome_type o;
         int          pos;
         int          i;
         o = '0;
         case (mode)
            MODE_INSERT: begin
               if (held_count >= DEPTH) begin
                  o.rejected = 1'b1;
               end else begin
                  for (i = held_count; i > 0; i--) held[i] = held[i - 1];
                  held[0] = value;
                  held_count++;
               end
            end
            MODE_FIND: begin
               o.hit = (locate(value) < held_count);
            end
            MODE_DELETE: begin
               pos = locate(value);
               if (pos < held_count) begin
                  o.hit = 1'b1;
                  for (i = pos; i + 1 < held_count; i++) held[i] = held[i + 1];
                  held_count--;
               end
            end
            default: ;
         endcase
         o.count      = CNT_W'(held_count);
         o.empty_flag = (held_count == 0);
         owed_q.push_back(o);
      endfunction

      // Compare one accepted response with the oldest owed outcome
      task check_response(input logic hit, input logic rejected,
                          input logic [CNT_W-1:0] count, input logic empty_flag);
         outcome_type o;
         if (owed_q.size() == 0) begin
            report("response with no request outstanding");
         end else begin
            o = owed_q.pop_front();
            if (hit !== o.hit)
               report($sformatf("hit %b, want %b", hit, o.hit));
            if (rejected !== o.rejected)
               report($sformatf("rejected %b, want %b", rejected, o.rejected));
            if (count !== o.count)
               report($sformatf("count %0d, want %0d", count, o.count));
            if (empty_flag !== o.empty_flag)
               report($sformatf("empty_res %b, want %b", empty_flag, o.empty_flag));
         end
      endtask

      function int pending();
         return owed_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, channels and the block under test
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pfsl_req_if                          req_ch ();
   pfsl_rsp_if #(.CAPACITY(CAPACITY))   rsp_ch ();

   push_front_search_list #(.CAPACITY(CAPACITY)) i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   list_scoreboard            sb = new();
   bit                        req_fire;
   bit                        gaps_on;
   bit                        rsp_quiet;
   bit                        hold_request;
   logic signed [VALUE_W-1:0] value_pool [8];

   initial begin
      req_ch.valid = 1'b0;
      req_ch.mode  = MODE_INSERT;
      req_ch.value = '0;
      rsp_ch.ready = 1'b1;
      req_fire     = 1'b0;
      gaps_on      = 1'b1;
      rsp_quiet    = 1'b0;
      hold_request = 1'b0;
      value_pool   = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1,
                       32'sd1, 32'sd7, 32'sh5555_5555, 32'shAAAA_AAAA};
   end

   // Sample both handshakes at the rising edge
   always @(posedge clock) begin
      req_fire = !reset && req_ch.valid && req_ch.ready;
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_response(rsp_ch.hit, rsp_ch.rejected, rsp_ch.count, rsp_ch.empty_res);
      if (req_fire)
         sb.note_request(req_ch.mode, req_ch.value);
   end

   // Response side: short random stalls, one long hold on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b1;
         end else if (!rsp_quiet && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Offer one transaction, optionally after a short gap, and wait for it
   task automatic send_op(input logic [MODE_W-1:0] m, input logic signed [VALUE_W-1:0] v);
      int unsigned gap;
      gap = 0;
      if (gaps_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 3);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode  <= m;
      req_ch.value <= v;
      do @(negedge clock); while (!req_fire);
   endtask

   // Mostly pool values or entries known to be held, so finds and deletes hit
   function automatic logic signed [VALUE_W-1:0] pick_value(input bit from_list);
      int unsigned r;
      r = $urandom_range(0, 9);
      if (from_list && sb.held_count > 0 && r < 5)
         return sb.held[$urandom_range(0, sb.held_count - 1)];
      if (r < 8) return value_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   // Bias towards inserts while filling and deletes while draining
   function automatic logic [MODE_W-1:0] pick_mode(input bit filling);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 2) return MODE_NOP;
      if (r < (filling ? 62 : 22)) return MODE_INSERT;
      if (r < (filling ? 82 : 42)) return MODE_FIND;
      return MODE_DELETE;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      logic [MODE_W-1:0] m;
      int                k;
      int                guard;

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Operations on an empty list
      send_op(MODE_FIND,   32'sh8000_0000);
      send_op(MODE_DELETE, 32'sh7FFF_FFFF);
      send_op(MODE_NOP,    32'sh0);
      // Extremes, then a find that hits and one that misses
      send_op(MODE_INSERT, 32'sh8000_0000);
      send_op(MODE_INSERT, 32'sh7FFF_FFFF);
      send_op(MODE_INSERT, 32'sh0);
      send_op(MODE_INSERT, -32'sd1);
      send_op(MODE_FIND,   32'sh7FFF_FFFF);
      send_op(MODE_FIND,   32'sd5);
      send_op(MODE_DELETE, 32'sh0);
      // Duplicates: delete drops only the first, find still hits
      send_op(MODE_INSERT, 32'sd7);
      send_op(MODE_INSERT, 32'sd7);
      send_op(MODE_DELETE, 32'sd7);
      send_op(MODE_FIND,   32'sd7);
      // Fill to capacity, then an insert that is refused
      for (k = 0; k < CAPACITY - 4; k++) send_op(MODE_INSERT, $urandom);
      send_op(MODE_INSERT, 32'sh1234_5678);
      send_op(MODE_NOP,    -32'sd1);
      send_op(MODE_DELETE, 32'sh8000_0000);

      // Random fill and drain phases
      for (k = 0; k < RAND_ITEMS; k++) begin
         if (k == HOLD_AT) hold_request = 1'b1;
         if (k == QUIET_FROM) begin
            gaps_on   = 1'b0;
            rsp_quiet = 1'b1;
         end
         m = pick_mode(((k / PHASE_LEN) % 2) == 0);
         send_op(m, pick_value(m != MODE_INSERT));
      end
      req_ch.valid <= 1'b0;

      // Drain outstanding responses, then let the pipeline settle
      guard = 0;
      while (sb.pending() != 0 && guard < 2000) begin
         @(negedge clock);
         guard++;
      end
      repeat (4) @(negedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d responses never arrived", sb.pending()));

      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run
   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
